// ===== sv/fnb_pkg.sv =====
// Shared types and constants for the four-neighbour blur core.
// Used by fnb_front, fnb_queue, fnb_back and four_neighbour_blur_core.
package fnb_pkg;

  localparam int unsigned CfgDataW = 11;
  localparam int unsigned SizeRst  = 1024;

  // Exact floor(x / 3) for x below 2048: (x * 683) >> 11.
  localparam int unsigned Div3Mul   = 683;
  localparam int unsigned Div3Shift = 11;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } nbr_mask_t;

  typedef struct packed {
    pix_t      up;
    pix_t      dn;
    pix_t      lf;
    pix_t      rt;
    nbr_mask_t mask;
    logic      last;
  } blur_job_t;

endpackage

// ===== sv/four_neighbour_blur_core.sv =====
// Four-neighbour blur core: front end, two-entry queue and arithmetic back end.
// Takes one beat per cycle while the queue has room; each store has one write and one
// prefetch read per cycle. A result passes the queue, sum and output registers.
// Results for row r come out while row r+1 arrives; width drain beats flush the last row.
// Reset clears counters and the queue and sets both sizes to 1024 (capped at the maxima);
// the line stores are not cleared and hold no valid data until written.
module four_neighbour_blur_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [0:0]                   cfg_index_i,
  input  logic [fnb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [7:0]                   in_red_i,
  input  logic [7:0]                   in_green_i,
  input  logic [7:0]                   in_blue_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   out_red_o,
  output logic [7:0]                   out_green_o,
  output logic [7:0]                   out_blue_o,
  output logic                         last_of_frame_o
);

  logic               fr_valid, fr_ready, bk_valid, bk_ready;
  fnb_pkg::blur_job_t fr_job, bk_job;

  fnb_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .in_red_i   (in_red_i),
    .in_green_i (in_green_i),
    .in_blue_i  (in_blue_i),
    .job_valid_o(fr_valid),
    .job_ready_i(fr_ready),
    .job_o      (fr_job)
  );

  fnb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_ready_o(fr_ready),
    .push_data_i (fr_job),
    .pop_valid_o (bk_valid),
    .pop_ready_i (bk_ready),
    .pop_data_o  (bk_job)
  );

  fnb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (bk_valid),
    .job_ready_o    (bk_ready),
    .job_i          (bk_job),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .last_of_frame_o(last_of_frame_o)
  );

endmodule

// ===== sv/fnb_front.sv =====
// Front end: frame counters, size registers and the two line stores.
// Classifies each beat and hands neighbour sets to the queue; uses fnb_pkg.
module fnb_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [0:0]                   cfg_index_i,
  input  logic [fnb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [7:0]                   in_red_i,
  input  logic [7:0]                   in_green_i,
  input  logic [7:0]                   in_blue_i,
  output logic                         job_valid_o,
  input  logic                         job_ready_i,
  output fnb_pkg::blur_job_t           job_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam logic [WW-1:0] WidthRst =
    WW'((MAX_WIDTH < fnb_pkg::SizeRst) ? MAX_WIDTH : fnb_pkg::SizeRst);
  localparam logic [RW-1:0] HeightRst =
    RW'((MAX_HEIGHT < fnb_pkg::SizeRst) ? MAX_HEIGHT : fnb_pkg::SizeRst);

  logic [WW-1:0] width_q;
  logic [RW-1:0] height_q;
  logic [WW-1:0] cfg_w;
  logic [RW-1:0] cfg_h;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW:0]   col_inc;
  logic          col_wrap;
  logic          cfg_wr, accept, is_pixel, action, emit;
  logic          abv_we, cur_we;

  fnb_pkg::pix_t abv_mem [MAX_WIDTH];
  fnb_pkg::pix_t cur_mem [MAX_WIDTH];
  fnb_pkg::pix_t abv_raw_q, cur_raw_q, abv_bypd_q, cur_bypd_q;
  logic          abv_byp_q, cur_byp_q;
  fnb_pkg::pix_t rd_abv, rd_cur, pix_in, centre;
  fnb_pkg::pix_t col0_q, ctr_q, left_q;
  logic [CW-1:0] cur_ra;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;
  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i & job_ready_i;
  assign is_pixel    = (opcode_i == fnb_pkg::OP_PIXEL);

  always_comb begin
    cfg_w = WW'(MAX_WIDTH);
    if (cfg_data_i == '0) begin
      cfg_w = WW'(1);
    end else if (32'(cfg_data_i) <= 32'(MAX_WIDTH)) begin
      cfg_w = WW'(cfg_data_i);
    end
    cfg_h = RW'(MAX_HEIGHT);
    if (cfg_data_i == '0) begin
      cfg_h = RW'(1);
    end else if (32'(cfg_data_i) <= 32'(MAX_HEIGHT)) begin
      cfg_h = RW'(cfg_data_i);
    end
  end

  assign col_inc  = {1'b0, col_q} + (CW+1)'(1);
  assign col_wrap = (32'(col_inc) >= 32'(width_q));

  assign action = accept & (is_pixel ? (row_q < height_q) : (row_q == height_q));
  assign emit   = action & (!is_pixel | (row_q != '0));
  assign abv_we = emit;
  assign cur_we = action & is_pixel;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_wr) begin
      col_d = '0;
      row_d = '0;
    end else if (action) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = is_pixel ? RW'(row_q + RW'(1)) : '0;
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WidthRst;
      height_q  <= HeightRst;
      col_q     <= '0;
      row_q     <= '0;
      abv_byp_q <= 1'b0;
      cur_byp_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (fnb_pkg::cfg_reg_e'(cfg_index_i))
          fnb_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_w;
          fnb_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_h;
          default: ;
        endcase
      end
      col_q     <= col_d;
      row_q     <= row_d;
      abv_byp_q <= abv_we && (col_d == col_q);
      cur_byp_q <= cur_we && (cur_ra == col_q);
    end
  end

  always_comb begin
    pix_in.red   = in_red_i;
    pix_in.green = in_green_i;
    pix_in.blue  = in_blue_i;
  end

  assign cur_ra = col_d + CW'(1);
  assign rd_abv = abv_byp_q ? abv_bypd_q : abv_raw_q;
  assign rd_cur = cur_byp_q ? cur_bypd_q : cur_raw_q;
  assign centre = (col_q == '0) ? col0_q : ctr_q;

  always_ff @(posedge clk_i) begin
    abv_raw_q  <= abv_mem[col_d];
    cur_raw_q  <= cur_mem[cur_ra];
    abv_bypd_q <= centre;
    cur_bypd_q <= pix_in;
    if (abv_we) begin
      abv_mem[col_q] <= centre;
    end
    if (cur_we) begin
      cur_mem[col_q] <= pix_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_we && (col_q == '0)) begin
      col0_q <= pix_in;
    end
    if (action) begin
      ctr_q  <= rd_cur;
      left_q <= centre;
    end
  end

  always_comb begin
    job_o.up      = rd_abv;
    job_o.dn      = pix_in;
    job_o.lf      = left_q;
    job_o.rt      = rd_cur;
    job_o.mask.up = is_pixel ? (row_q > RW'(1)) : (height_q > RW'(1));
    job_o.mask.dn = is_pixel;
    job_o.mask.lf = (col_q != '0);
    job_o.mask.rt = !col_wrap;
    job_o.last    = !is_pixel & col_wrap;
    if (job_o.mask == '0) begin
      job_o.mask.up = 1'b1;
      job_o.up      = centre;
    end
  end

  assign job_valid_o = emit;

endmodule

// ===== sv/fnb_queue.sv =====
// Two-entry queue of neighbour sets between the front and back ends.
// Uses the job type from fnb_pkg.
module fnb_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  fnb_pkg::blur_job_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output fnb_pkg::blur_job_t pop_data_o
);

  fnb_pkg::blur_job_t mem_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;
  logic               push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/fnb_back.sv =====
// Back end: sums the valid neighbours per channel, then divides by their count.
// Two pipeline stages ending in the output register; uses fnb_pkg.
module fnb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  fnb_pkg::blur_job_t job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_red_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_blue_o,
  output logic               last_of_frame_o
);

  function automatic logic [9:0] chan_sum(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c, input logic [7:0] d,
                                          input fnb_pkg::nbr_mask_t m);
    logic [9:0] s;
    s = (m.up ? {2'b00, a} : 10'd0) + (m.dn ? {2'b00, b} : 10'd0)
      + (m.lf ? {2'b00, c} : 10'd0) + (m.rt ? {2'b00, d} : 10'd0);
    return s;
  endfunction

  function automatic logic [7:0] div_n(input logic [9:0] s, input logic [2:0] n);
    logic [19:0] prod;
    logic [7:0]  q;
    prod = 20'(s) * 20'(fnb_pkg::Div3Mul);
    case (n)
      3'd1:    q = s[7:0];
      3'd2:    q = s[8:1];
      3'd3:    q = prod[fnb_pkg::Div3Shift +: 8];
      3'd4:    q = s[9:2];
      default: q = 8'd0;
    endcase
    return q;
  endfunction

  logic       s1_valid_q, s1_ready, s2_ready;
  logic [9:0] s1_red_q, s1_green_q, s1_blue_q;
  logic [2:0] s1_n_q;
  logic       s1_last_q;
  logic       out_valid_q;

  assign s2_ready    = !out_valid_q || out_ready_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign job_ready_o = s1_ready;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= job_valid_i;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && job_valid_i) begin
      s1_red_q   <= chan_sum(job_i.up.red, job_i.dn.red, job_i.lf.red, job_i.rt.red,
                             job_i.mask);
      s1_green_q <= chan_sum(job_i.up.green, job_i.dn.green, job_i.lf.green,
                             job_i.rt.green, job_i.mask);
      s1_blue_q  <= chan_sum(job_i.up.blue, job_i.dn.blue, job_i.lf.blue,
                             job_i.rt.blue, job_i.mask);
      s1_n_q     <= 3'($countones(job_i.mask));
      s1_last_q  <= job_i.last;
    end
    if (s2_ready && s1_valid_q) begin
      out_red_o       <= div_n(s1_red_q, s1_n_q);
      out_green_o     <= div_n(s1_green_q, s1_n_q);
      out_blue_o      <= div_n(s1_blue_q, s1_n_q);
      last_of_frame_o <= s1_last_q;
    end
  end

endmodule
